@@ hw/rtl/sste_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted set table engine package
// Shared constants, widths and codes for the sorted set table engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sste_pkg;

  localparam int unsigned Capacity  = 64;
  localparam int unsigned KeyWidth  = 32;
  localparam int unsigned IdxWidth  = $clog2(Capacity);
  localparam int unsigned CntWidth  = $clog2(Capacity + 1);

  typedef logic [KeyWidth-1:0] key_t;
  typedef logic [IdxWidth-1:0] idx_t;
  typedef logic [CntWidth-1:0] cnt_t;

  // Request operation codes.
  typedef enum logic [3:0] {
    OP_INSERT  = 4'd0,
    OP_REMOVE  = 4'd1,
    OP_EXISTS  = 4'd2,
    OP_MIN     = 4'd3,
    OP_MAX     = 4'd4,
    OP_RMMIN   = 4'd5,
    OP_RMMAX   = 4'd6,
    OP_PRED    = 4'd7,
    OP_SUCC    = 4'd8,
    OP_RMPRED  = 4'd9,
    OP_RMSUCC  = 4'd10,
    OP_CLEAR   = 4'd11
  } op_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_SWAIT,
    S_DECIDE,
    S_RDEND,
    S_RWAIT,
    S_MVRD,
    S_MVWR,
    S_FINAL,
    S_OUT
  } state_e;

endpackage

`default_nettype wire

@@ hw/rtl/sste_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sste_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

@@ hw/rtl/sorted_set_table_engine_top.sv @@
// ----------------------------------------------------------------------------
// Sorted set table engine
// Ordered set of distinct keys in a circular single-port memory.
// ----------------------------------------------------------------------------
// One request is handled at a time. A keyed request runs a binary search of
// at most log2(capacity)+1 probes through the single memory port, then an
// insert or removal moves the shorter side one entry at a time (read, then
// write), at most capacity/2 moves. The result is held in an output register
// and the next request is taken once it leaves.
`default_nettype none

module sorted_set_table_engine_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [3:0]  op_i,
  input  wire logic [31:0] key_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [31:0]      value_o,
  output logic [6:0]       count_o
);

  localparam int unsigned CW = sste_pkg::CntWidth;
  localparam int unsigned IW = sste_pkg::IdxWidth;

  sste_pkg::state_e state_q, state_d;
  sste_pkg::cnt_t   head_q, head_d;     // head index (IW bits used)
  sste_pkg::cnt_t   cnt_q, cnt_d;
  logic [3:0]       op_q, op_d;
  sste_pkg::key_t   key_q, key_d;
  sste_pkg::cnt_t   lo_q, lo_d, hi_q, hi_d;
  sste_pkg::cnt_t   pos_q, pos_d;       // offset to act on
  sste_pkg::cnt_t   mv_q, mv_d;         // move counter offset
  logic             dir_q, dir_d;       // 1: move upper side, 0: lower side
  logic             ins_q, ins_d;
  sste_pkg::key_t   mvdata_q, mvdata_d;
  logic [2:0]       st_q, st_d;
  sste_pkg::key_t   val_q, val_d;

  logic             we;
  sste_pkg::idx_t   addr;
  sste_pkg::key_t   wdata, rdata;
  sste_pkg::cnt_t   mid;

  function automatic sste_pkg::idx_t slot(sste_pkg::cnt_t h, sste_pkg::cnt_t o);
    logic [CW:0] s;
    s = {1'b0, h} + {1'b0, o};
    return s[IW-1:0];
  endfunction

  sste_ram #(.Width(sste_pkg::KeyWidth), .Depth(sste_pkg::Capacity)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  // Next-state and datapath update.
  always_comb begin
    state_d = state_q; head_d = head_q; cnt_d = cnt_q; op_d = op_q; key_d = key_q;
    lo_d = lo_q; hi_d = hi_q; pos_d = pos_q; mv_d = mv_q; dir_d = dir_q;
    ins_d = ins_q; mvdata_d = mvdata_q; st_d = st_q; val_d = val_q;
    case (state_q)
      sste_pkg::S_IDLE: begin
        if (in_valid_i) begin
          op_d = op_i; key_d = key_i[sste_pkg::KeyWidth-1:0];
          lo_d = '0; hi_d = cnt_q; st_d = sste_pkg::ST_OK; val_d = '0;
          ins_d = 1'b0;
          case (op_i) inside
            sste_pkg::OP_CLEAR: begin
              head_d = '0; cnt_d = '0; state_d = sste_pkg::S_OUT;
            end
            sste_pkg::OP_MIN, sste_pkg::OP_MAX, sste_pkg::OP_RMMIN, sste_pkg::OP_RMMAX: begin
              if (cnt_q == '0) begin
                st_d = sste_pkg::ST_EMPTY; state_d = sste_pkg::S_OUT;
              end else begin
                state_d = sste_pkg::S_RDEND;
              end
            end
            [4'd12:4'd15]: begin
              st_d = sste_pkg::ST_NOTFOUND; state_d = sste_pkg::S_OUT;
            end
            default: state_d = sste_pkg::S_SRCH;
          endcase
        end
      end
      sste_pkg::S_SRCH: begin
        state_d = (lo_q < hi_q) ? sste_pkg::S_SWAIT : sste_pkg::S_DECIDE;
        pos_d = lo_q;
        if (!(lo_q < hi_q) && lo_q < cnt_q) state_d = sste_pkg::S_RWAIT;
      end
      sste_pkg::S_SWAIT: begin
        if ((op_q == sste_pkg::OP_SUCC || op_q == sste_pkg::OP_RMSUCC)
            ? (rdata <= key_q) : (rdata < key_q)) lo_d = mid + 1'b1;
        else hi_d = mid;
        state_d = sste_pkg::S_SRCH;
      end
      sste_pkg::S_RWAIT: begin
        // Key at the search position is now on the read port.
        mvdata_d = rdata;
        state_d = sste_pkg::S_DECIDE;
      end
      sste_pkg::S_DECIDE: begin
        state_d = sste_pkg::S_OUT;
        case (op_q)
          sste_pkg::OP_INSERT: begin
            if (pos_q < cnt_q && mvdata_q == key_q) st_d = sste_pkg::ST_DUP;
            else if (cnt_q >= CW'(sste_pkg::Capacity)) st_d = sste_pkg::ST_FULL;
            else begin
              ins_d = 1'b1;
              dir_d = (pos_q >= cnt_q - pos_q);
              mv_d = dir_d ? cnt_q : '0;
              state_d = sste_pkg::S_MVRD;
            end
          end
          sste_pkg::OP_REMOVE, sste_pkg::OP_EXISTS: begin
            if (pos_q < cnt_q && mvdata_q == key_q) begin
              val_d = key_q;
              if (op_q == sste_pkg::OP_REMOVE) begin
                dir_d = (pos_q >= cnt_q - pos_q - 1'b1);
                mv_d = pos_q; state_d = sste_pkg::S_MVRD;
              end
            end else st_d = sste_pkg::ST_NOTFOUND;
          end
          sste_pkg::OP_SUCC, sste_pkg::OP_RMSUCC: begin
            if (pos_q >= cnt_q) st_d = sste_pkg::ST_NOTFOUND;
            else begin
              val_d = mvdata_q;
              if (op_q == sste_pkg::OP_RMSUCC) begin
                dir_d = (pos_q >= cnt_q - pos_q - 1'b1);
                mv_d = pos_q; state_d = sste_pkg::S_MVRD;
              end
            end
          end
          default: begin
            // Predecessor: read the entry just below the search position.
            if (pos_q == '0) st_d = sste_pkg::ST_NOTFOUND;
            else begin
              pos_d = pos_q - 1'b1;
              op_d = (op_q == sste_pkg::OP_RMPRED) ? sste_pkg::OP_RMSUCC : sste_pkg::OP_SUCC;
              state_d = sste_pkg::S_RWAIT;
            end
          end
        endcase
      end
      sste_pkg::S_RDEND: begin
        state_d = sste_pkg::S_OUT;
        val_d = rdata;
        if (op_q == sste_pkg::OP_RMMIN) begin
          head_d = CW'(slot(head_q, CW'(1))); cnt_d = cnt_q - 1'b1;
        end else if (op_q == sste_pkg::OP_RMMAX) begin
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == CW'(1)) head_d = '0;
        end
      end
      sste_pkg::S_MVRD: begin
        // Issue the read of the neighbour or finish.
        if (ins_q) begin
          if (dir_q) state_d = (mv_q > pos_q) ? sste_pkg::S_MVWR : sste_pkg::S_FINAL;
          else state_d = (mv_q < pos_q) ? sste_pkg::S_MVWR : sste_pkg::S_FINAL;
        end else begin
          if (dir_q) state_d = (mv_q + 1'b1 < cnt_q) ? sste_pkg::S_MVWR : sste_pkg::S_FINAL;
          else state_d = (mv_q > '0) ? sste_pkg::S_MVWR : sste_pkg::S_FINAL;
        end
      end
      sste_pkg::S_MVWR: begin
        state_d = sste_pkg::S_MVRD;
        if (ins_q) mv_d = dir_q ? mv_q - 1'b1 : mv_q + 1'b1;
        else mv_d = dir_q ? mv_q + 1'b1 : mv_q - 1'b1;
      end
      sste_pkg::S_FINAL: begin
        state_d = sste_pkg::S_OUT;
        if (ins_q) begin
          if (!dir_q) head_d = CW'(slot(head_q, CW'(sste_pkg::Capacity - 1)));
          cnt_d = cnt_q + 1'b1;
        end else begin
          if (!dir_q) head_d = CW'(slot(head_q, CW'(1)));
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == CW'(1)) head_d = '0;
        end
      end
      sste_pkg::S_OUT: begin
        if (out_ready_i) state_d = sste_pkg::S_IDLE;
      end
      default: state_d = sste_pkg::S_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    we = 1'b0; wdata = rdata; addr = slot(head_q, mid);
    case (state_q)
      sste_pkg::S_SRCH: begin
        addr = (lo_q < hi_q) ? slot(head_q, mid) : slot(head_q, lo_q);
      end
      sste_pkg::S_DECIDE: addr = slot(head_q, pos_q - 1'b1);
      sste_pkg::S_IDLE: begin
        addr = (op_i == sste_pkg::OP_MIN || op_i == sste_pkg::OP_RMMIN)
               ? slot(head_q, '0) : slot(head_q, cnt_q - 1'b1);
      end
      sste_pkg::S_MVRD: begin
        if (ins_q) addr = dir_q ? slot(head_q, mv_q - 1'b1) : slot(head_q, mv_q);
        else addr = dir_q ? slot(head_q, mv_q + 1'b1) : slot(head_q, mv_q - 1'b1);
      end
      sste_pkg::S_MVWR: begin
        we = 1'b1;
        if (ins_q) addr = dir_q ? slot(head_q, mv_q)
                                : slot(head_q, mv_q + CW'(sste_pkg::Capacity - 1));
        else addr = slot(head_q, mv_q);
      end
      sste_pkg::S_FINAL: begin
        if (ins_q) begin
          we = 1'b1; wdata = key_q;
          addr = dir_q ? slot(head_q, pos_q) : slot(head_q, pos_q + CW'(sste_pkg::Capacity - 1));
        end
      end
      default: ;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready_o  = (state_q == sste_pkg::S_IDLE);
    out_valid_o = (state_q == sste_pkg::S_OUT);
    status_o    = st_q;
    value_o     = val_q;
    count_o     = cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sste_pkg::S_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; key_q <= key_d; lo_q <= lo_d; hi_q <= hi_d; pos_q <= pos_d;
    mv_q <= mv_d; dir_q <= dir_d; ins_q <= ins_d; mvdata_q <= mvdata_d;
    st_q <= st_d; val_q <= val_d;
  end

  // Count never exceeds capacity.
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(sste_pkg::Capacity)) else $error("count above capacity");
  // The head index always points inside the store.
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q < CW'(sste_pkg::Capacity))
    else $error("head index outside the store");
  // Memory writes happen only during the move phase.
  a_we_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == sste_pkg::S_MVWR || state_q == sste_pkg::S_FINAL))
    else $error("write outside move phase");
  // Outside idle, the count changes by at most one at a time.
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != sste_pkg::S_IDLE) |=> (cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + 1'b1
    || cnt_q == $past(cnt_q) - 1'b1)) else $error("count jumped");

endmodule

`default_nettype wire
